>>> design/hgig_pkg.sv
// Shared types, codes, constants and shape tables of the Hangul glyph index generator.
// Depends on nothing; every module of the block imports it.
package hgig_pkg;

   // Kind of glyph carried with a result.
   typedef enum logic [1:0] {
      KIND_ASCII   = 2'd0,
      KIND_HANGUL  = 2'd1,
      KIND_INVALID = 2'd2
   } glyph_kind_type;

   // Syllable block bounds and jamo counts.
   localparam logic [15:0] SYLLABLE_FIRST = 16'hAC00;
   localparam logic [15:0] SYLLABLE_LAST  = 16'hD7A3;
   localparam logic [13:0] FINAL_COUNT    = 14'd28;
   localparam logic [8:0]  MEDIAL_COUNT   = 9'd21;

   // Reciprocal of the final count scaled by 2^20 and of the medial count scaled by 2^16.
   // Both give the exact quotient over the whole syllable range.
   localparam logic [15:0] RECIP_FINAL  = 16'd37450;
   localparam logic [11:0] RECIP_MEDIAL = 12'd3121;

   // Bank strides of the glyph indices.
   localparam logic [7:0] INITIAL_STRIDE = 8'd20;
   localparam logic [6:0] MEDIAL_STRIDE  = 7'd22;
   localparam logic [6:0] FINAL_STRIDE   = 7'd28;

   // Final shape by medial jamo.
   localparam logic [1:0] FINAL_SHAPE [0:21] = '{
      2'd0, 2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd3, 2'd0,
      2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd1
   };

   // Medial shape by initial jamo times two plus the final flag.
   localparam logic [1:0] MEDIAL_SHAPE [0:39] = '{
      2'd1, 2'd3, 2'd0, 2'd2, 2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3,
      2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3,
      2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3,
      2'd1, 2'd3, 2'd0, 2'd2, 2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3
   };

   // Initial shape by medial jamo times two plus the final flag.
   localparam logic [2:0] INITIAL_SHAPE [0:43] = '{
      3'd0, 3'd0, 3'd0, 3'd5, 3'd0, 3'd5, 3'd0, 3'd5, 3'd0, 3'd5, 3'd0,
      3'd5, 3'd0, 3'd5, 3'd0, 3'd5, 3'd0, 3'd5, 3'd1, 3'd6, 3'd3, 3'd7,
      3'd3, 3'd7, 3'd3, 3'd7, 3'd1, 3'd6, 3'd2, 3'd6, 3'd4, 3'd7, 3'd4,
      3'd7, 3'd4, 3'd7, 3'd2, 3'd6, 3'd1, 3'd6, 3'd3, 3'd7, 3'd0, 3'd5
   };

   // Character after decoding: kind, ASCII code and offset into the syllable block.
   typedef struct packed {
      glyph_kind_type kind;
      logic [6:0]     ascii;
      logic [13:0]    offset;
   } decode_type;

   // Syllable split into jamo numbers (initial 1..19, medial 1..21, final 0..27).
   typedef struct packed {
      glyph_kind_type kind;
      logic [6:0]     ascii;
      logic [4:0]     initial_jamo;
      logic [4:0]     medial_jamo;
      logic [4:0]     final_jamo;
   } split_type;

   // Finished result item.
   typedef struct packed {
      glyph_kind_type kind;
      logic [6:0]     ascii_code;
      logic [7:0]     initial_glyph;
      logic [6:0]     medial_glyph;
      logic [6:0]     final_glyph;
      logic           final_present;
   } result_type;

endpackage

>>> design/hangul_glyph_index_generator_core.sv
// Top level of the Hangul glyph index generator: stream ports and the five-stage pipeline.
// Depends on hgig_pkg, hgig_decode, hgig_divide and hgig_shape.
//
//   Channel  Direction  Contents
//   req_*    in         one character as three UTF-8 bytes
//   rsp_*    out        glyph kind and the glyph indices of the three font banks
//
// One character enters per cycle while rsp_tready does not stall the pipeline, and its
// result is offered on rsp_* from the last of five register stages: decode, three
// stages for the reciprocal multiplications that replace the division by 28 and
// by 21, and the shape lookup.
// Reset clears the valid bits of all stages. A stall on rsp_tready holds each full
// stage whose later stages are all full; empty stages ahead of it keep accepting transfers.
module hangul_glyph_index_generator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // lead_byte [7:0], second_byte [15:8], third_byte [23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // ascii_code [6:0], initial_glyph [14:7],
                                   // medial_glyph [21:15], final_glyph [28:22],
                                   // final_present [29], zero [31:30]
   output logic [1:0]  rsp_tuser   // glyph_kind [1:0]
);
   import hgig_pkg::*;

   logic       dec_valid;
   logic       dec_ready;
   decode_type dec_data;
   logic       div_valid;
   logic       div_ready;
   split_type  div_data;
   result_type result;

   // Decode stage.
   hgig_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .lead_byte   (req_tdata[7:0]),
      .second_byte (req_tdata[15:8]),
      .third_byte  (req_tdata[23:16]),
      .out_valid   (dec_valid),
      .out_ready   (dec_ready),
      .out_data    (dec_data)
   );

   // Jamo split stages.
   hgig_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   // Shape lookup and output register.
   hgig_shape u_shape (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (result)
   );

   // Pack the result transfer.
   assign rsp_tdata = {2'b00, result.final_present, result.final_glyph,
                       result.medial_glyph, result.initial_glyph, result.ascii_code};
   assign rsp_tuser = result.kind;

endmodule

>>> design/hgig_decode.sv
// First pipeline stage: UTF-8 bytes to code point, kind and syllable offset.
// Depends on hgig_pkg.
module hgig_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [7:0]         lead_byte,
   input  logic [7:0]         second_byte,
   input  logic [7:0]         third_byte,
   output logic               out_valid,
   input  logic               out_ready,
   output hgig_pkg::decode_type out_data
);
   import hgig_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   decode_type data_ff;
   decode_type data_in;
   logic [15:0] code_point;

   // The stage takes a transfer when it is empty or its content moves on.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Classify the character and take the syllable offset.
   always_comb begin
      code_point = {lead_byte[3:0], second_byte[5:0], third_byte[5:0]};
      data_in = '0;
      if (!lead_byte[7]) begin
         data_in.kind  = KIND_ASCII;
         data_in.ascii = lead_byte[6:0];
      end else if (code_point < SYLLABLE_FIRST || code_point > SYLLABLE_LAST) begin
         data_in.kind = KIND_INVALID;
      end else begin
         data_in.kind   = KIND_HANGUL;
         data_in.offset = 14'(code_point - SYLLABLE_FIRST);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> design/hgig_divide.sv
// Three pipeline stages that split the syllable offset into jamo numbers
// by reciprocal multiplication. Depends on hgig_pkg.
module hgig_divide (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hgig_pkg::decode_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hgig_pkg::split_type  out_data
);
   import hgig_pkg::*;

   // Stage A: quotient by the final count.
   logic           a_valid_ff;
   glyph_kind_type a_kind_ff;
   logic [6:0]     a_ascii_ff;
   logic [13:0]    a_offset_ff;
   logic [8:0]     a_quot_ff;
   logic [29:0]    a_prod_in;
   logic           a_ready;

   // Stage B: final jamo and the product for the medial split.
   logic           b_valid_ff;
   glyph_kind_type b_kind_ff;
   logic [6:0]     b_ascii_ff;
   logic [4:0]     b_final_ff;
   logic [8:0]     b_quot_ff;
   logic [20:0]    b_prod_ff;
   logic [4:0]     b_final_in;
   logic [20:0]    b_prod_in;
   logic           b_ready;

   // Stage C: initial and medial jamo.
   logic           c_valid_ff;
   split_type      c_data_ff;
   split_type      c_data_in;
   logic [4:0]     c_init_in;
   logic           c_ready;

   // Each stage moves when it is empty or the next one takes its content.
   assign c_ready  = !c_valid_ff || out_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // Stage A arithmetic: the quotient sits in bits 28 to 20 of the product.
   assign a_prod_in = 30'(in_data.offset) * 30'(RECIP_FINAL);

   // Stage B arithmetic: remainder by the final count, product by the medial reciprocal.
   assign b_final_in = 5'(a_offset_ff - 14'(a_quot_ff) * FINAL_COUNT);
   assign b_prod_in  = 21'(a_quot_ff) * 21'(RECIP_MEDIAL);

   // Stage C arithmetic: quotient and remainder by the medial count, jamo from one.
   always_comb begin
      c_init_in              = b_prod_ff[20:16];
      c_data_in.kind         = b_kind_ff;
      c_data_in.ascii        = b_ascii_ff;
      c_data_in.final_jamo   = b_final_ff;
      c_data_in.initial_jamo = 5'(c_init_in + 5'd1);
      c_data_in.medial_jamo  = 5'(b_quot_ff - 9'(c_init_in) * MEDIAL_COUNT + 9'd1);
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_ready) begin
            c_valid_ff <= b_valid_ff;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_kind_ff   <= in_data.kind;
         a_ascii_ff  <= in_data.ascii;
         a_offset_ff <= in_data.offset;
         a_quot_ff   <= a_prod_in[28:20];
      end
      if (b_ready) begin
         b_kind_ff  <= a_kind_ff;
         b_ascii_ff <= a_ascii_ff;
         b_final_ff <= b_final_in;
         b_quot_ff  <= a_quot_ff;
         b_prod_ff  <= b_prod_in;
      end
      if (c_ready) begin
         c_data_ff <= c_data_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_data  = c_data_ff;

endmodule

>>> design/hgig_shape.sv
// Last pipeline stage and output register: shape table lookups and glyph indices.
// Depends on hgig_pkg.
module hgig_shape (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hgig_pkg::split_type  in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hgig_pkg::result_type out_data
);
   import hgig_pkg::*;

   logic       valid_ff;
   result_type data_ff;
   result_type data_in;
   logic       has_final;
   logic [1:0] final_shape;
   logic [1:0] medial_shape;
   logic [2:0] initial_shape;
   logic [5:0] medial_index;
   logic [5:0] initial_index;

   assign in_ready = !valid_ff || out_ready;

   // Look up the three shapes and form the bank indices.
   always_comb begin
      has_final     = in_data.final_jamo != 5'd0;
      medial_index  = {in_data.initial_jamo, has_final};
      initial_index = {in_data.medial_jamo, has_final};
      final_shape   = (in_data.medial_jamo <= 5'd21) ? FINAL_SHAPE[in_data.medial_jamo] : 2'd0;
      medial_shape  = (medial_index <= 6'd39) ? MEDIAL_SHAPE[medial_index] : 2'd0;
      initial_shape = (initial_index <= 6'd43) ? INITIAL_SHAPE[initial_index] : 3'd0;
      data_in       = '0;
      data_in.kind  = in_data.kind;
      case (in_data.kind)
         KIND_ASCII: begin
            data_in.ascii_code = in_data.ascii;
         end
         KIND_HANGUL: begin
            data_in.initial_glyph = 8'(8'(initial_shape) * INITIAL_STRIDE
                                       + 8'(in_data.initial_jamo));
            data_in.medial_glyph  = 7'(7'(medial_shape) * MEDIAL_STRIDE
                                       + 7'(in_data.medial_jamo));
            if (has_final) begin
               data_in.final_glyph = 7'(7'(final_shape) * FINAL_STRIDE
                                        + 7'(in_data.final_jamo));
            end
            data_in.final_present = has_final;
         end
         default: begin
            data_in.kind = KIND_INVALID;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
